// ===== design/lli_pkg.sv =====
// ----------------------------------------------------------------------------
// lli_pkg: shared types and widths for the line intersection pipeline
// Derived widths of the Cramer's-rule datapath and the divider beat.
// ----------------------------------------------------------------------------
package lli_pkg;

    localparam int COORD_BITS      = 16;
    localparam int COORD_FRAC_BITS = 4;
    localparam int OUT_FRAC_BITS   = 16;
    localparam int OUT_BITS        = 32;

    localparam int DIF_W  = COORD_BITS + 1;            // direction difference
    localparam int PD_W   = 2 * DIF_W;                 // det partial product
    localparam int DET_W  = PD_W + 1;                  // determinant
    localparam int PP_W   = DIF_W + COORD_BITS;        // p/q partial product
    localparam int PQ_W   = PP_W + 1;                  // p, q
    localparam int NP_W   = DIF_W + PQ_W;              // numerator product
    localparam int NUM_W  = NP_W + 1;                  // d1, d2
    localparam int SHIFT  = OUT_FRAC_BITS - COORD_FRAC_BITS;
    localparam int Q_W    = OUT_BITS + 1;              // quotient bits computed
    localparam int MAG_W  = DET_W;                     // |det| and remainder
    localparam int REM_W  = MAG_W + 1;
    localparam int N_W    = NUM_W + SHIFT;             // scaled dividend
    localparam int CMP_W  = MAG_W + Q_W;
    localparam int FRONT_STAGES = 7;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   bits;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        logic [MAG_W-1:0] den;
        logic             found;
        t_lane            lx;
        t_lane            ly;
    } t_div;

endpackage

// ===== design/lli_front.sv =====
// ----------------------------------------------------------------------------
// lli_front: determinant and numerators
// Differences, products, sums and magnitudes; prepares the divider beat.
// ----------------------------------------------------------------------------
module lli_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a1_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a1_y,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a2_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a2_y,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b1_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b1_y,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b2_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b2_y,
    output logic                                  o_valid,
    output lli_pkg::t_div                         o_d
);
    import lli_pkg::*;

    logic [FRONT_STAGES-1:0] r_v;

    // stage 1
    logic signed [DIF_W-1:0]      r_lx, r_ly, r_kx, r_ky;
    logic signed [COORD_BITS-1:0] r_xa, r_ya, r_xb, r_yb;
    // stage 2
    logic signed [PD_W-1:0]  r_m1, r_m2;
    logic signed [PP_W-1:0]  r_p1, r_p2, r_q1, r_q2;
    logic signed [DIF_W-1:0] r2_lx, r2_ly, r2_kx, r2_ky;
    // stage 3
    logic signed [DET_W-1:0] r3_det;
    logic signed [PQ_W-1:0]  r_p, r_q;
    logic signed [DIF_W-1:0] r3_lx, r3_ly, r3_kx, r3_ky;
    // stage 4
    logic signed [NP_W-1:0]  r_n1, r_n2, r_n3, r_n4;
    logic signed [DET_W-1:0] r4_det;
    // stage 5
    logic signed [NUM_W-1:0] r_d1, r_d2;
    logic signed [DET_W-1:0] r5_det;
    // stage 6
    logic [NUM_W-1:0] r_m_x, r_m_y;
    logic [MAG_W-1:0] r_den;
    logic             r_neg_x, r_neg_y, r_found;
    // stage 7
    t_div             r_out;

    logic [N_W-1:0]   w_nx, w_ny;
    logic [CMP_W-1:0] w_lim;

    always_comb begin
        w_nx  = {r_m_x, {SHIFT{1'b0}}};
        w_ny  = {r_m_y, {SHIFT{1'b0}}};
        w_lim = CMP_W'(r_den) << (Q_W - SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lx <= DIF_W'(i_a2_x) - DIF_W'(i_a1_x);
            r_ly <= DIF_W'(i_a2_y) - DIF_W'(i_a1_y);
            r_kx <= DIF_W'(i_b2_x) - DIF_W'(i_b1_x);
            r_ky <= DIF_W'(i_b2_y) - DIF_W'(i_b1_y);
            r_xa <= i_a1_x;
            r_ya <= i_a1_y;
            r_xb <= i_b1_x;
            r_yb <= i_b1_y;

            r_m1  <= r_lx * r_ky;
            r_m2  <= r_ly * r_kx;
            r_p1  <= r_ly * r_xa;
            r_p2  <= r_lx * r_ya;
            r_q1  <= r_ky * r_xb;
            r_q2  <= r_kx * r_yb;
            r2_lx <= r_lx;
            r2_ly <= r_ly;
            r2_kx <= r_kx;
            r2_ky <= r_ky;

            r3_det <= DET_W'(r_m1) - DET_W'(r_m2);
            r_p    <= PQ_W'(r_p1) - PQ_W'(r_p2);
            r_q    <= PQ_W'(r_q1) - PQ_W'(r_q2);
            r3_lx  <= r2_lx;
            r3_ly  <= r2_ly;
            r3_kx  <= r2_kx;
            r3_ky  <= r2_ky;

            r_n1   <= r3_lx * r_q;
            r_n2   <= r3_kx * r_p;
            r_n3   <= r3_ly * r_q;
            r_n4   <= r3_ky * r_p;
            r4_det <= r3_det;

            r_d1   <= NUM_W'(r_n1) - NUM_W'(r_n2);
            r_d2   <= NUM_W'(r_n3) - NUM_W'(r_n4);
            r5_det <= r4_det;

            r_m_x   <= r_d1[NUM_W-1] ? NUM_W'(-r_d1) : NUM_W'(r_d1);
            r_m_y   <= r_d2[NUM_W-1] ? NUM_W'(-r_d2) : NUM_W'(r_d2);
            r_den   <= r5_det[DET_W-1] ? MAG_W'(-r5_det) : MAG_W'(r5_det);
            r_neg_x <= r_d1[NUM_W-1] ^ r5_det[DET_W-1];
            r_neg_y <= r_d2[NUM_W-1] ^ r5_det[DET_W-1];
            r_found <= (r5_det != '0);

            // quotient overflow when |num| << SHIFT >= |det| << Q_W
            r_out.den      <= r_den;
            r_out.found    <= r_found;
            r_out.lx.rem   <= MAG_W'(w_nx[N_W-1:Q_W]);
            r_out.lx.bits  <= w_nx[Q_W-1:0];
            r_out.lx.quo   <= '0;
            r_out.lx.neg   <= r_neg_x;
            r_out.lx.ovf   <= (CMP_W'(r_m_x) >= w_lim);
            r_out.ly.rem   <= MAG_W'(w_ny[N_W-1:Q_W]);
            r_out.ly.bits  <= w_ny[Q_W-1:0];
            r_out.ly.quo   <= '0;
            r_out.ly.neg   <= r_neg_y;
            r_out.ly.ovf   <= (CMP_W'(r_m_y) >= w_lim);
        end
    end

    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_d     = r_out;

endmodule

// ===== design/lli_cell.sv =====
// ----------------------------------------------------------------------------
// lli_cell: one restoring-division step
// Produces one quotient bit for each coordinate and passes the beat on.
// ----------------------------------------------------------------------------
module lli_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  lli_pkg::t_div i_d,
    output logic          o_valid,
    output lli_pkg::t_div o_d
);
    import lli_pkg::*;

    logic  r_valid;
    t_div  r_d;
    t_div  n_d;

    function automatic t_lane step(input t_lane l, input logic [MAG_W-1:0] den);
        logic [REM_W-1:0] r2;
        logic             ge;
        t_lane            o;
        r2     = {l.rem, l.bits[Q_W-1]};
        ge     = (r2 >= REM_W'(den));
        o      = l;
        o.rem  = ge ? MAG_W'(r2 - REM_W'(den)) : MAG_W'(r2);
        o.bits = {l.bits[Q_W-2:0], 1'b0};
        o.quo  = {l.quo[Q_W-2:0], ge};
        return o;
    endfunction

    always_comb begin
        n_d    = i_d;
        n_d.lx = step(i_d.lx, i_d.den);
        n_d.ly = step(i_d.ly, i_d.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

// ===== design/line_line_intersection.sv =====
// ----------------------------------------------------------------------------
// line_line_intersection: Cramer's-rule intersection of two lines
// Full pipeline: arithmetic front end, a chain of divide cells, output stage.
// ----------------------------------------------------------------------------
// Usage notes
// - Input channel: i_valid / o_stall, one beat carries two lines, each as two
//   points in signed Q12.4. A beat is taken when i_valid is high and o_stall
//   low.
// - Output channel: o_valid / i_stall, one beat per input beat with found,
//   cross_x, cross_y (signed Q16.16) and saturated.
// - Throughput: one beat per cycle, sustained, as long as i_stall stays low.
// - Pipeline: 7 front-end stages, one cell per quotient bit (33 cells), then
//   the output register.
// - The divider is a row of identical cells; each resolves one quotient bit
//   of both coordinates and hands its remainder to the next cell.
// - Parallel lines (zero determinant) give found = 0 and zero elsewhere.
// - Quotients outside the signed 32-bit output range are clamped and raise saturated.
// - Stall: while the output beat waits, the whole pipe holds and o_stall
//   goes high; beats already inside are kept, none are dropped.
// - Reset (synchronous, active low) empties the pipe; payload is not cleared.
// ----------------------------------------------------------------------------
module line_line_intersection (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a1_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a1_y,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a2_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_a2_y,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b1_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b1_y,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b2_x,
    input  logic signed [lli_pkg::COORD_BITS-1:0] i_b2_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_found,
    output logic signed [lli_pkg::OUT_BITS-1:0]   o_cross_x,
    output logic signed [lli_pkg::OUT_BITS-1:0]   o_cross_y,
    output logic                                  o_saturated
);
    import lli_pkg::*;

    logic w_adv;
    logic w_v [0:Q_W];
    t_div w_d [0:Q_W];

    logic r_out_valid;
    logic r_found, r_sat;
    logic signed [OUT_BITS-1:0] r_x, r_y;

    logic [Q_W-1:0]      w_lim_x, w_lim_y, w_mag_x, w_mag_y;
    logic                w_sat_x, w_sat_y;
    logic [OUT_BITS-1:0] w_val_x, w_val_y;

    // whole pipe moves unless a finished beat is held at the output
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    lli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_a1_x  (i_a1_x),
        .i_a1_y  (i_a1_y),
        .i_a2_x  (i_a2_x),
        .i_a2_y  (i_a2_y),
        .i_b1_x  (i_b1_x),
        .i_b1_y  (i_b1_y),
        .i_b2_x  (i_b2_x),
        .i_b2_y  (i_b2_y),
        .o_valid (w_v[0]),
        .o_d     (w_d[0])
    );

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        lli_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_v[g]),
            .i_d     (w_d[g]),
            .o_valid (w_v[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    // clamp: +2^31-1 for positive results, -2^31 for negative
    always_comb begin
        w_lim_x = w_d[Q_W].lx.neg ? (Q_W'(1) << (OUT_BITS - 1))
                                  : (Q_W'(1) << (OUT_BITS - 1)) - Q_W'(1);
        w_lim_y = w_d[Q_W].ly.neg ? (Q_W'(1) << (OUT_BITS - 1))
                                  : (Q_W'(1) << (OUT_BITS - 1)) - Q_W'(1);
        w_sat_x = w_d[Q_W].lx.ovf || (w_d[Q_W].lx.quo > w_lim_x);
        w_sat_y = w_d[Q_W].ly.ovf || (w_d[Q_W].ly.quo > w_lim_y);
        w_mag_x = w_sat_x ? w_lim_x : w_d[Q_W].lx.quo;
        w_mag_y = w_sat_y ? w_lim_y : w_d[Q_W].ly.quo;
        w_val_x = w_d[Q_W].lx.neg ? OUT_BITS'(-w_mag_x) : OUT_BITS'(w_mag_x);
        w_val_y = w_d[Q_W].ly.neg ? OUT_BITS'(-w_mag_y) : OUT_BITS'(w_mag_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_v[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_found <= w_d[Q_W].found;
            r_x     <= w_d[Q_W].found ? w_val_x : '0;
            r_y     <= w_d[Q_W].found ? w_val_y : '0;
            r_sat   <= w_d[Q_W].found && (w_sat_x || w_sat_y);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_found;
    assign o_cross_x   = r_x;
    assign o_cross_y   = r_y;
    assign o_saturated = r_sat;

endmodule

// ===== design/lli_checker.sv =====
// ----------------------------------------------------------------------------
// lli_checker: port-level checks for line_line_intersection
// Watches the result channel and the stall relation; bound to the top level.
// ----------------------------------------------------------------------------
module lli_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic                                o_found,
    input logic signed [lli_pkg::OUT_BITS-1:0] o_cross_x,
    input logic signed [lli_pkg::OUT_BITS-1:0] o_cross_y,
    input logic                                o_saturated
);
    // input is held back only by a waiting result beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result beat");

    // parallel lines give an all-zero result
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_cross_x == '0 && o_cross_y == '0
                                   && !o_saturated))
        else $error("parallel result not zero");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result beat dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_cross_x) && $stable(o_cross_y)
                                  && $stable(o_found) && $stable(o_saturated)))
        else $error("stalled result beat changed");

endmodule

bind line_line_intersection lli_checker u_lli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_found     (o_found),
    .o_cross_x   (o_cross_x),
    .o_cross_y   (o_cross_y),
    .o_saturated (o_saturated)
);
